// ----- design/mwm_pkg.sv -----
// Shared types and constants for the maze wall map updater.
package mwm_pkg;

   // Map word width and bit masks.
   localparam int WORD_W = 11;
   localparam logic [WORD_W-1:0] MASK_SHAPE = 11'h600;
   localparam logic [WORD_W-1:0] MASK_COLOR = 11'h100;
   localparam logic [WORD_W-1:0] MASK_WV    = 11'h080;
   localparam logic [WORD_W-1:0] MASK_W     = 11'h040;
   localparam logic [WORD_W-1:0] MASK_NV    = 11'h020;
   localparam logic [WORD_W-1:0] MASK_N     = 11'h010;
   localparam logic [WORD_W-1:0] MASK_EV    = 11'h008;
   localparam logic [WORD_W-1:0] MASK_E     = 11'h004;
   localparam logic [WORD_W-1:0] MASK_SV    = 11'h002;
   localparam logic [WORD_W-1:0] MASK_S     = 11'h001;

   // Heading codes; the side the robot faces is never pushed.
   localparam logic [1:0] HEAD_S = 2'd0;
   localparam logic [1:0] HEAD_W = 2'd1;
   localparam logic [1:0] HEAD_N = 2'd2;
   localparam logic [1:0] HEAD_E = 2'd3;

   // Result kinds.
   localparam logic KIND_MAP  = 1'b0;
   localparam logic KIND_PUSH = 1'b1;

   // Program counter width and fixed entry points.
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_CLEAR = 4'd0;
   localparam logic [PC_W-1:0] PC_WAIT  = 4'd1;

   // Input word.
   typedef struct packed {
      logic [2:0] cell_x;
      logic [2:0] cell_y;
      logic       wall_west;
      logic       wall_north;
      logic       wall_east;
      logic       wall_south;
      logic [1:0] treasure_shape;
      logic       treasure_color;
      logic [1:0] heading;
   } req_type;

   // Result word.
   typedef struct packed {
      logic              kind;
      logic [2:0]        out_x;
      logic [2:0]        out_y;
      logic [WORD_W-1:0] map_word;
      logic              last;
   } rsp_type;

   // Micro-operations, one-hot.
   typedef enum logic [5:0] {
      OP_CLEAR = 6'b000001,
      OP_WAIT  = 6'b000010,
      OP_ADDR  = 6'b000100,
      OP_UPD   = 6'b001000,
      OP_PUSH  = 6'b010000,
      OP_OWN   = 6'b100000
   } op_type;

   // Side of the explored cell that a step works on.
   typedef enum logic [1:0] {
      SIDE_W = 2'd0,
      SIDE_N = 2'd1,
      SIDE_E = 2'd2,
      SIDE_S = 2'd3
   } side_type;

   // One control word of the program.
   typedef struct packed {
      op_type          op;
      side_type        side;
      logic [PC_W-1:0] target;
   } ctrl_type;

   // Conditions the datapath reports back to the sequencer.
   typedef struct packed {
      logic in_grid;
      logic on_grid;
      logic clear_done;
   } stat_type;

endpackage

// ----- design/mwm_seq.sv -----
// Microcode sequencer: program counter, control store and jump logic.
module mwm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  mwm_pkg::stat_type stat,
   output mwm_pkg::ctrl_type ctrl
);

   logic [mwm_pkg::PC_W-1:0] pc_ff;
   logic [mwm_pkg::PC_W-1:0] pc_in;

   // Control store. Each side takes an address, an update and a push step.
   function automatic mwm_pkg::ctrl_type rom(input logic [mwm_pkg::PC_W-1:0] pc);
      mwm_pkg::ctrl_type w;
      case (pc)
         4'd0:    w = '{mwm_pkg::OP_CLEAR, mwm_pkg::SIDE_W, mwm_pkg::PC_WAIT};
         4'd1:    w = '{mwm_pkg::OP_WAIT,  mwm_pkg::SIDE_W, 4'd2};
         4'd2:    w = '{mwm_pkg::OP_ADDR,  mwm_pkg::SIDE_W, 4'd5};
         4'd3:    w = '{mwm_pkg::OP_UPD,   mwm_pkg::SIDE_W, 4'd4};
         4'd4:    w = '{mwm_pkg::OP_PUSH,  mwm_pkg::SIDE_W, 4'd5};
         4'd5:    w = '{mwm_pkg::OP_ADDR,  mwm_pkg::SIDE_N, 4'd8};
         4'd6:    w = '{mwm_pkg::OP_UPD,   mwm_pkg::SIDE_N, 4'd7};
         4'd7:    w = '{mwm_pkg::OP_PUSH,  mwm_pkg::SIDE_N, 4'd8};
         4'd8:    w = '{mwm_pkg::OP_ADDR,  mwm_pkg::SIDE_E, 4'd11};
         4'd9:    w = '{mwm_pkg::OP_UPD,   mwm_pkg::SIDE_E, 4'd10};
         4'd10:   w = '{mwm_pkg::OP_PUSH,  mwm_pkg::SIDE_E, 4'd11};
         4'd11:   w = '{mwm_pkg::OP_ADDR,  mwm_pkg::SIDE_S, 4'd14};
         4'd12:   w = '{mwm_pkg::OP_UPD,   mwm_pkg::SIDE_S, 4'd13};
         4'd13:   w = '{mwm_pkg::OP_PUSH,  mwm_pkg::SIDE_S, 4'd14};
         4'd14:   w = '{mwm_pkg::OP_OWN,   mwm_pkg::SIDE_W, mwm_pkg::PC_WAIT};
         default: w = '{mwm_pkg::OP_CLEAR, mwm_pkg::SIDE_W, mwm_pkg::PC_WAIT};
      endcase
      return w;
   endfunction

   assign ctrl = rom(pc_ff);

   // Next step: fall through, hold, or jump to the word's target.
   always_comb begin
      pc_in = pc_ff + 4'd1;
      case (ctrl.op)
         mwm_pkg::OP_CLEAR: begin
            pc_in = stat.clear_done ? ctrl.target : pc_ff;
         end
         mwm_pkg::OP_WAIT: begin
            pc_in = (accept && stat.in_grid) ? ctrl.target : pc_ff;
         end
         mwm_pkg::OP_ADDR: begin
            if (!stat.on_grid) begin
               pc_in = ctrl.target;
            end
         end
         mwm_pkg::OP_OWN: begin
            pc_in = ctrl.target;
         end
         default: begin
            pc_in = pc_ff + 4'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= mwm_pkg::PC_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- design/mwm_dp.sv -----
// Datapath: request latch, map and visited memories, word update and result register.
module mwm_dp #(
   parameter int GRID_W = 8,
   parameter int GRID_H = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  mwm_pkg::req_type  req_data,
   input  mwm_pkg::ctrl_type ctrl,
   output mwm_pkg::stat_type stat,
   output logic              rsp_strobe,
   output mwm_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = mwm_pkg::WORD_W;

   logic [WW-1:0]    wall_mem [DEPTH];
   logic             vis_mem  [DEPTH];
   logic [WW-1:0]    rd_wall_ff;
   logic             rd_vis_ff;

   mwm_pkg::req_type req_ff, req_in;
   mwm_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic [3:0]       nb_x, nb_y;
   logic             nb_inside, nb_wall, nb_blocked;
   logic [WW-1:0]    nb_wmask, nb_vmask;
   logic [AW-1:0]    nb_idx, own_idx, addr;
   logic [WW-1:0]    upd_word, own_word, wall_wd;
   logic             wall_we, vis_we, vis_wd, push_ok;

   // Latch the input word when it is accepted.
   assign req_in = accept ? req_data : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Neighbor coordinates, edge test and masks for the current side.
   always_comb begin
      nb_x       = {1'b0, req_ff.cell_x};
      nb_y       = {1'b0, req_ff.cell_y};
      nb_inside  = 1'b0;
      nb_wall    = 1'b0;
      nb_blocked = 1'b0;
      nb_wmask   = '0;
      nb_vmask   = '0;
      case (ctrl.side)
         mwm_pkg::SIDE_W: begin
            nb_x       = {1'b0, req_ff.cell_x} - 4'd1;
            nb_inside  = (req_ff.cell_x != 3'd0);
            nb_wall    = req_ff.wall_west;
            nb_blocked = (req_ff.heading == mwm_pkg::HEAD_W);
            nb_wmask   = mwm_pkg::MASK_E;
            nb_vmask   = mwm_pkg::MASK_EV;
         end
         mwm_pkg::SIDE_N: begin
            nb_y       = {1'b0, req_ff.cell_y} - 4'd1;
            nb_inside  = (req_ff.cell_y != 3'd0);
            nb_wall    = req_ff.wall_north;
            nb_blocked = (req_ff.heading == mwm_pkg::HEAD_N);
            nb_wmask   = mwm_pkg::MASK_S;
            nb_vmask   = mwm_pkg::MASK_SV;
         end
         mwm_pkg::SIDE_E: begin
            nb_x       = {1'b0, req_ff.cell_x} + 4'd1;
            nb_inside  = (32'(nb_x) < GRID_W);
            nb_wall    = req_ff.wall_east;
            nb_blocked = (req_ff.heading == mwm_pkg::HEAD_E);
            nb_wmask   = mwm_pkg::MASK_W;
            nb_vmask   = mwm_pkg::MASK_WV;
         end
         mwm_pkg::SIDE_S: begin
            nb_y       = {1'b0, req_ff.cell_y} + 4'd1;
            nb_inside  = (32'(nb_y) < GRID_H);
            nb_wall    = req_ff.wall_south;
            nb_blocked = (req_ff.heading == mwm_pkg::HEAD_S);
            nb_wmask   = mwm_pkg::MASK_N;
            nb_vmask   = mwm_pkg::MASK_NV;
         end
         default: begin
            nb_inside = 1'b0;
         end
      endcase
   end

   // Row-major memory indexes of the neighbor and of the explored cell.
   assign nb_idx  = AW'(32'(nb_y) * GRID_W + 32'(nb_x));
   assign own_idx = AW'(32'(req_ff.cell_y) * GRID_W + 32'(req_ff.cell_x));

   always_comb begin
      case (ctrl.op)
         mwm_pkg::OP_CLEAR: addr = clr_ff;
         mwm_pkg::OP_OWN:   addr = own_idx;
         default:           addr = nb_idx;
      endcase
   end

   // Shared wall of the neighbor: set or clear the wall, always set valid.
   assign upd_word = (nb_wall ? (rd_wall_ff | nb_wmask) : (rd_wall_ff & ~nb_wmask))
                     | nb_vmask;
   assign push_ok  = !nb_wall && !nb_blocked && !rd_vis_ff;

   // The explored cell's own word is built fresh; no shape clears the treasure bits.
   always_comb begin
      own_word = mwm_pkg::MASK_WV | mwm_pkg::MASK_NV | mwm_pkg::MASK_EV | mwm_pkg::MASK_SV;
      if (req_ff.wall_west)  own_word = own_word | mwm_pkg::MASK_W;
      if (req_ff.wall_north) own_word = own_word | mwm_pkg::MASK_N;
      if (req_ff.wall_east)  own_word = own_word | mwm_pkg::MASK_E;
      if (req_ff.wall_south) own_word = own_word | mwm_pkg::MASK_S;
      if (req_ff.treasure_shape != 2'd0) begin
         own_word[10:9] = req_ff.treasure_shape;
         own_word[8]    = req_ff.treasure_color;
      end
   end

   // Memory write controls per micro-operation.
   always_comb begin
      wall_we = 1'b0;
      wall_wd = '0;
      vis_we  = 1'b0;
      vis_wd  = 1'b0;
      case (ctrl.op)
         mwm_pkg::OP_CLEAR: begin
            wall_we = 1'b1;
            vis_we  = 1'b1;
         end
         mwm_pkg::OP_UPD: begin
            wall_we = 1'b1;
            wall_wd = upd_word;
         end
         mwm_pkg::OP_PUSH: begin
            vis_we = push_ok;
            vis_wd = 1'b1;
         end
         mwm_pkg::OP_OWN: begin
            wall_we = 1'b1;
            wall_wd = own_word;
         end
         default: begin
            wall_we = 1'b0;
         end
      endcase
   end

   // Map and visited memories: at most one write and one registered read per cycle, the read only in an address step.
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[addr] <= wall_wd;
      end
      if (vis_we) begin
         vis_mem[addr] <= vis_wd;
      end
      if (ctrl.op == mwm_pkg::OP_ADDR) begin
         rd_wall_ff <= wall_mem[addr];
         rd_vis_ff  <= vis_mem[addr];
      end
   end

   // Clearing pass counter after reset.
   assign clr_in = (ctrl.op == mwm_pkg::OP_CLEAR) ? clr_ff + AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Result word for the current step.
   always_comb begin
      rsp_strobe_in    = 1'b0;
      rsp_in.kind      = mwm_pkg::KIND_MAP;
      rsp_in.out_x     = nb_x[2:0];
      rsp_in.out_y     = nb_y[2:0];
      rsp_in.map_word  = upd_word;
      rsp_in.last      = 1'b0;
      case (ctrl.op)
         mwm_pkg::OP_UPD: begin
            rsp_strobe_in = 1'b1;
         end
         mwm_pkg::OP_PUSH: begin
            rsp_strobe_in   = push_ok;
            rsp_in.kind     = mwm_pkg::KIND_PUSH;
            rsp_in.map_word = '0;
         end
         mwm_pkg::OP_OWN: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.out_x    = req_ff.cell_x;
            rsp_in.out_y    = req_ff.cell_y;
            rsp_in.map_word = own_word;
            rsp_in.last     = 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Status back to the sequencer.
   assign stat.in_grid    = (32'(req_data.cell_x) < GRID_W) && (32'(req_data.cell_y) < GRID_H);
   assign stat.on_grid    = nb_inside;
   assign stat.clear_done = (clr_ff == AW'(DEPTH - 1));

endmodule

// ----- design/maze_wall_map_update.sv -----
// Top level of the maze wall map updater.
//
// Usage: present one explored cell on req_data and raise start; the word is
// taken at a rising edge where start is high and busy is low. For each side
// the block updates the in-grid neighbor's shared wall and emits its new map
// word, pushes an open, unvisited, not-excluded neighbor as a frontier word,
// and ends with the cell's own map word, flagged by last.
// Results appear on rsp_data for one cycle each, marked by rsp_strobe; the
// receiver cannot stall them. Each side takes only an address step when its
// neighbor is off the grid, else an address, an update and a push step, and
// a final step writes the own word; each result is registered before it
// shows. busy drops in the cycle that shows the last result, and a new cell
// is not taken before then. A cell outside the grid gives no result and
// leaves busy low. The pace is set by the single memory port the microcode
// program walks through step by step.
// After reset the block clears both stores, one entry per cycle, with busy
// high until every entry is clear.
module maze_wall_map_update #(
   parameter int GRID_W = 8,
   parameter int GRID_H = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mwm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mwm_pkg::rsp_type rsp_data
);

   mwm_pkg::ctrl_type ctrl;
   mwm_pkg::stat_type stat;
   logic              accept;

   assign busy   = (ctrl.op != mwm_pkg::OP_WAIT);
   assign accept = start && !busy;

   mwm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .ctrl   (ctrl)
   );

   mwm_dp #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // The final result of a cell arrives just as the block is free again.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> !busy)
      else $error("last result while still busy");

   // Results before the own-cell word appear only while the program runs.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("intermediate result while idle");

   // The clearing pass produces no results.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == mwm_pkg::OP_CLEAR) |=> !rsp_strobe)
      else $error("result during clearing pass");

   // Frontier pushes carry a zero map word and are never the last result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.kind == mwm_pkg::KIND_PUSH)
         |-> (rsp_data.map_word == '0 && !rsp_data.last))
      else $error("malformed frontier push");

endmodule

// ----- tb/maze_wall_map_update_test.sv -----
// Self-checking testbench for the maze wall map updater.
module maze_wall_map_update_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_W = 8;
   localparam int GRID_H = 8;
   localparam int CELLS = GRID_W * GRID_H;
   localparam int IDLE_MAX = 9;
   localparam int CALM_TAIL = 40;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 20;
   localparam int MIXED_CELLS = 360;
   localparam int REQ_W = $bits(mwm_pkg::req_type);
   localparam int WW = mwm_pkg::WORD_W;

   // One cell word waiting to be sent; drain holds it until all results are in.
   typedef struct {
      mwm_pkg::req_type word;
      bit               drain;
   } cell_job_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   mwm_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   mwm_pkg::rsp_type rsp_data;

   cell_job_type cell_queue[$];
   cell_job_type job_now;
   mwm_pkg::rsp_type predicted_updates[$];
   bit [WW-1:0] map_mirror[CELLS];
   bit visited_mirror[CELLS];
   bit east_wall[GRID_W][GRID_H];
   bit south_wall[GRID_W][GRID_H];

   int total_jobs = 0;
   int words_taken = 0;
   int mismatches = 0;
   int gap_left = 0;
   int stall_cycles = 0;
   bit idle_mode = 1'b1;

   maze_wall_map_update DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Update one neighbor's shared wall, then push it when open and allowed.
   function automatic void touch_neighbor(bit on_grid, int nx, int ny, logic wall,
         logic [WW-1:0] wall_bit, logic [WW-1:0] valid_bit, bit excluded);
      int idx;
      bit [WW-1:0] word;
      mwm_pkg::rsp_type r;
      if (!on_grid) return;
      idx = ny * GRID_W + nx;
      word = wall ? (map_mirror[idx] | wall_bit) : (map_mirror[idx] & ~wall_bit);
      word = word | valid_bit;
      map_mirror[idx] = word;
      r.kind = mwm_pkg::KIND_MAP;
      r.out_x = nx[2:0];
      r.out_y = ny[2:0];
      r.map_word = word;
      r.last = 1'b0;
      predicted_updates.push_back(r);
      if (!wall && !excluded && !visited_mirror[idx]) begin
         visited_mirror[idx] = 1'b1;
         r.kind = mwm_pkg::KIND_PUSH;
         r.map_word = '0;
         predicted_updates.push_back(r);
      end
   endfunction

   // Work out every map write and frontier push that one explored cell causes.
   function automatic void predict_cell(mwm_pkg::req_type c);
      int x;
      int y;
      bit [WW-1:0] own;
      mwm_pkg::rsp_type r;
      x = int'(c.cell_x);
      y = int'(c.cell_y);
      if (x >= GRID_W || y >= GRID_H) return;
      own = mwm_pkg::MASK_WV | mwm_pkg::MASK_NV | mwm_pkg::MASK_EV | mwm_pkg::MASK_SV;
      if (c.wall_west) own = own | mwm_pkg::MASK_W;
      if (c.wall_north) own = own | mwm_pkg::MASK_N;
      if (c.wall_east) own = own | mwm_pkg::MASK_E;
      if (c.wall_south) own = own | mwm_pkg::MASK_S;
      touch_neighbor(x > 0, x - 1, y, c.wall_west, mwm_pkg::MASK_E, mwm_pkg::MASK_EV,
                     c.heading == mwm_pkg::HEAD_W);
      touch_neighbor(y > 0, x, y - 1, c.wall_north, mwm_pkg::MASK_S, mwm_pkg::MASK_SV,
                     c.heading == mwm_pkg::HEAD_N);
      touch_neighbor(x < GRID_W - 1, x + 1, y, c.wall_east, mwm_pkg::MASK_W,
                     mwm_pkg::MASK_WV, c.heading == mwm_pkg::HEAD_E);
      touch_neighbor(y < GRID_H - 1, x, y + 1, c.wall_south, mwm_pkg::MASK_N,
                     mwm_pkg::MASK_NV, c.heading == mwm_pkg::HEAD_S);
      // With no treasure, shape and color stay clear whatever the color input says.
      if (c.treasure_shape != 2'd0)
         own = own | {c.treasure_shape, c.treasure_color, 8'd0};
      map_mirror[y * GRID_W + x] = own;
      r.kind = mwm_pkg::KIND_MAP;
      r.out_x = c.cell_x;
      r.out_y = c.cell_y;
      r.map_word = own;
      r.last = 1'b1;
      predicted_updates.push_back(r);
   endfunction

   function automatic mwm_pkg::req_type make_word(int x, int y, logic [3:0] walls,
         logic [1:0] shape, logic color, logic [1:0] head);
      mwm_pkg::req_type w;
      w.cell_x = x[2:0];
      w.cell_y = y[2:0];
      {w.wall_west, w.wall_north, w.wall_east, w.wall_south} = walls;
      w.treasure_shape = shape;
      w.treasure_color = color;
      w.heading = head;
      return w;
   endfunction

   task automatic add_job(mwm_pkg::req_type w, bit drain);
      cell_job_type j;
      j.word = w;
      j.drain = drain;
      cell_queue.push_back(j);
   endtask

   // Draw a fresh maze; outer walls are implied by the grid edge.
   task automatic new_maze();
      for (int x = 0; x < GRID_W; x++)
         for (int y = 0; y < GRID_H; y++) begin
            east_wall[x][y] = ($urandom_range(0, 2) == 0);
            south_wall[x][y] = ($urandom_range(0, 2) == 0);
         end
   endtask

   // Cell word that agrees with the current maze, with random treasure and heading.
   function automatic mwm_pkg::req_type maze_word(int x, int y);
      logic [3:0] walls;
      logic [1:0] shape;
      walls[3] = (x == 0) ? 1'b1 : east_wall[x - 1][y];
      walls[2] = (y == 0) ? 1'b1 : south_wall[x][y - 1];
      walls[1] = (x == GRID_W - 1) ? 1'b1 : east_wall[x][y];
      walls[0] = (y == GRID_H - 1) ? 1'b1 : south_wall[x][y];
      shape = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      return make_word(x, y, walls, shape, 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
   endfunction

   // Depth-first walk of the current maze, jumping to a fresh cell when cut off.
   task automatic explore_maze();
      bit seen[GRID_W][GRID_H] = '{default: 1'b0};
      int stack_x[$];
      int stack_y[$];
      int x;
      int y;
      int left;
      bit first;
      left = CELLS;
      first = 1'b1;
      while (left > 0) begin
         if (stack_x.size() == 0) begin
            do begin
               x = $urandom_range(0, GRID_W - 1);
               y = $urandom_range(0, GRID_H - 1);
            end while (seen[x][y]);
         end else begin
            x = stack_x.pop_back();
            y = stack_y.pop_back();
            if (seen[x][y]) continue;
         end
         seen[x][y] = 1'b1;
         left--;
         add_job(maze_word(x, y), first);
         first = 1'b0;
         if (x > 0 && !east_wall[x - 1][y] && !seen[x - 1][y]) begin
            stack_x.push_back(x - 1);
            stack_y.push_back(y);
         end
         if (y > 0 && !south_wall[x][y - 1] && !seen[x][y - 1]) begin
            stack_x.push_back(x);
            stack_y.push_back(y - 1);
         end
         if (x < GRID_W - 1 && !east_wall[x][y] && !seen[x + 1][y]) begin
            stack_x.push_back(x + 1);
            stack_y.push_back(y);
         end
         if (y < GRID_H - 1 && !south_wall[x][y] && !seen[x][y + 1]) begin
            stack_x.push_back(x);
            stack_y.push_back(y + 1);
         end
      end
   endtask

   // Driver: sends the queued cell words, with idle bursts and drain pauses.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            predict_cell(req_data);
            words_taken++;
            if ($urandom_range(0, 29) == 0) idle_mode = !idle_mode;
         end
         if (start && busy) begin
            // Still waiting for the block to take the word.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (idle_mode && cell_queue.size() > CALM_TAIL
                      && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, IDLE_MAX) - 1;
            start <= 1'b0;
         end else if (cell_queue.size() > 0
                      && !(cell_queue[0].drain && predicted_updates.size() != 0)) begin
            job_now = cell_queue.pop_front();
            req_data <= job_now.word;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      mwm_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (predicted_updates.size() == 0) begin
            report_mismatch("result with nothing expected", int'(rsp_data), 0);
         end else begin
            want = predicted_updates.pop_front();
            if (rsp_data.kind !== want.kind)
               report_mismatch("kind", int'(rsp_data.kind), int'(want.kind));
            if (rsp_data.out_x !== want.out_x)
               report_mismatch("out_x", int'(rsp_data.out_x), int'(want.out_x));
            if (rsp_data.out_y !== want.out_y)
               report_mismatch("out_y", int'(rsp_data.out_y), int'(want.out_y));
            if (rsp_data.map_word !== want.map_word)
               report_mismatch("map_word", int'(rsp_data.map_word), int'(want.map_word));
            if (rsp_data.last !== want.last)
               report_mismatch("last", int'(rsp_data.last), int'(want.last));
         end
      end
   end

   // Watchdog: ends the run when neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL maze_wall_map_update");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      // Corners with every wall open or closed, each heading and each treasure code.
      add_job(make_word(0, 0, 4'b0000, 2'd0, 1'b1, mwm_pkg::HEAD_S), 1'b0);
      add_job(make_word(7, 7, 4'b0000, 2'd3, 1'b1, mwm_pkg::HEAD_W), 1'b0);
      add_job(make_word(7, 0, 4'b1111, 2'd1, 1'b0, mwm_pkg::HEAD_N), 1'b0);
      add_job(make_word(0, 7, 4'b1111, 2'd2, 1'b1, mwm_pkg::HEAD_E), 1'b0);
      // Open cell in the middle; a second visit only pushes what is still new.
      add_job(make_word(3, 3, 4'b0000, 2'd0, 1'b0, mwm_pkg::HEAD_S), 1'b0);
      add_job(make_word(3, 3, 4'b0000, 2'd3, 1'b0, mwm_pkg::HEAD_N), 1'b1);
      // The explored cell itself is not marked, so a neighbor can still push it.
      add_job(make_word(2, 3, 4'b1101, 2'd1, 1'b1, mwm_pkg::HEAD_W), 1'b0);
      add_job(make_word(4, 4, 4'b1010, 2'd3, 1'b0, mwm_pkg::HEAD_E), 1'b0);
      add_job(make_word(5, 2, 4'b0000, 2'd2, 1'b0, mwm_pkg::HEAD_E), 1'b0);
      add_job(make_word(1, 6, 4'b0110, 2'd0, 1'b0, mwm_pkg::HEAD_N), 1'b0);
      add_job(make_word(6, 1, 4'b0101, 2'd2, 1'b1, mwm_pkg::HEAD_W), 1'b0);
      add_job(make_word(0, 0, 4'b1111, 2'd0, 1'b1, mwm_pkg::HEAD_S), 1'b1);
      // Consistent explorations of two random mazes.
      repeat (2) begin
         new_maze();
         explore_maze();
      end
      // Mostly maze-consistent words in random order, some pure noise.
      for (int i = 0; i < MIXED_CELLS; i++) begin
         mwm_pkg::req_type w;
         if (i % 100 == 50) new_maze();
         if ($urandom_range(0, 9) < 7)
            w = maze_word($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
         else
            w = REQ_W'($urandom());
         add_job(w, i % 75 == 0);
      end
      total_jobs = cell_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < total_jobs || predicted_updates.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS maze_wall_map_update");
      else
         $display("FAIL maze_wall_map_update");
      $finish;
   end

endmodule
